### design/gfw_pkg.sv
// Shared types, constants and helper functions for the glyph framebuffer writer.
package gfw_pkg;

	// Font store geometry: 128 glyphs of 8 rows, one byte per row.
	localparam int unsigned FONT_CHARS   = 128;
	localparam int unsigned FONT_ROWS    = 8;
	localparam int unsigned FONT_DEPTH   = FONT_CHARS * FONT_ROWS;
	localparam int unsigned FONT_ADDR_W  = $clog2(FONT_DEPTH);
	localparam int unsigned GLYPH_W      = $clog2(FONT_CHARS);
	// Pixel and row counters cover glyphs of up to 8 by 8 pixels.
	localparam int unsigned CNT_W        = 3;

	// Reset values of the configuration registers.
	localparam logic [31:0] FRAME_BASE_RST = 32'h0000_0000;
	localparam logic [15:0] LINE_PITCH_RST = 16'd4096;
	localparam logic        RGB_ORDER_RST  = 1'b1;

	// Request modes.
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_LETTER = 2'd1,
		MODE_HEX    = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_FRAME_BASE = 2'd0,
		CFG_LINE_PITCH = 2'd1,
		CFG_RGB_ORDER  = 2'd2
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic font_wr;   // write one font row from the request
		logic start;     // latch a draw request
		logic setup;     // form the pitch times line product
		logic load_base; // form the glyph's first pixel address
		logic emit;      // produce one pixel write
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a pixel this cycle
		logic last_px;   // current pixel is the glyph's final one
	} ctrl_sts_t;

	// Maps the low nibble of a code to the glyph of '0'-'9' or 'A'-'F'.
	function automatic logic [GLYPH_W-1:0] hex_glyph(input logic [7:0] code);
		logic [GLYPH_W-1:0] g;
		g = GLYPH_W'(8'h30) + GLYPH_W'(code[3:0]);
		if (code[3:0] > 4'h9) begin
			g = g + GLYPH_W'(7);
		end
		return g;
	endfunction

	// Optionally swaps the red and blue bytes; the top byte is cleared only when swapping.
	function automatic logic [31:0] order_colour(input logic [31:0] c, input logic swap);
		if (swap) begin
			return {8'h00, c[7:0], c[15:8], c[23:16]};
		end
		return c;
	endfunction

endpackage

### design/gfw_req_if.sv
// Request channel carrying font loads and glyph draws.
interface gfw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  cell_col;
	logic [7:0]  cell_row;
	logic [7:0]  char_code;
	logic [31:0] colour;
	logic [2:0]  font_row;
	logic [7:0]  font_bits;

	modport source (
		output valid, mode, cell_col, cell_row, char_code, colour, font_row, font_bits,
		input  ready
	);
	modport sink (
		input  valid, mode, cell_col, cell_row, char_code, colour, font_row, font_bits,
		output ready
	);
endinterface

### design/gfw_pix_if.sv
// Pixel write channel toward the framebuffer.
interface gfw_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] write_address;
	logic [31:0] pixel_value;
	logic        last_pixel;

	modport source (
		output valid, write_address, pixel_value, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, write_address, pixel_value, last_pixel,
		output ready
	);
endinterface

### design/glyph_to_framebuffer_writer.sv
// Top level of the glyph framebuffer writer: 8x8 bitmap font text-cell renderer.
//
// A load request writes one 8-bit row of the 128-glyph font store. A draw
// request renders one glyph as GLYPH_ROWS*GLYPH_COLS pixel writes, top row
// first and left to right, with bit 0 of a font row as the leftmost pixel; a set
// bit writes the colour and a clear bit writes black. The accepting cycle
// latches the request, the SETUP and BASE states form the line_pitch product
// and the glyph's base address, then the single pixel output register takes one
// write per cycle while the sink is ready and stalls while it is not. The next
// request is taken in the cycle after the last pixel is registered, while that
// pixel may still wait at the output. The font store has no reset; glyphs must
// be loaded before they are drawn. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module glyph_to_framebuffer_writer #(
	parameter int unsigned GLYPH_ROWS = 8,
	parameter int unsigned GLYPH_COLS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	gfw_req_if.sink     req,
	gfw_pix_if.source   pix
);

	gfw_pkg::ctrl_cmd_t cmd;
	gfw_pkg::ctrl_sts_t sts;
	logic               req_ready;

	// Sequencing of loads and draws.
	gfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	assign req.ready = req_ready;

	// Font store, address arithmetic and pixel output.
	gfw_datapath #(
		.GLYPH_ROWS (GLYPH_ROWS),
		.GLYPH_COLS (GLYPH_COLS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_mode          (req.mode),
		.req_cell_col      (req.cell_col),
		.req_cell_row      (req.cell_row),
		.req_char_code     (req.char_code),
		.req_colour        (req.colour),
		.req_font_row      (req.font_row),
		.req_font_bits     (req.font_bits),
		.pix_ready         (pix.ready),
		.pix_valid         (pix.valid),
		.pix_write_address (pix.write_address),
		.pix_pixel_value   (pix.pixel_value),
		.pix_last_pixel    (pix.last_pixel),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

### design/gfw_ctrl.sv
// Controller state machine sequencing font loads and glyph draws.
module gfw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_mode,
	input  gfw_pkg::ctrl_sts_t  sts,
	output logic                req_ready,
	output gfw_pkg::ctrl_cmd_t  cmd
);

	gfw_pkg::state_t state_q;
	gfw_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			gfw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (gfw_pkg::mode_t'(req_mode))
						gfw_pkg::MODE_LOAD: begin
							cmd.font_wr = 1'b1;
						end
						gfw_pkg::MODE_LETTER, gfw_pkg::MODE_HEX: begin
							cmd.start = 1'b1;
							state_d   = gfw_pkg::ST_SETUP;
						end
						default: begin
							// Unused mode: the request is dropped.
						end
					endcase
				end
			end
			gfw_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = gfw_pkg::ST_BASE;
			end
			gfw_pkg::ST_BASE: begin
				cmd.load_base = 1'b1;
				state_d       = gfw_pkg::ST_RUN;
			end
			gfw_pkg::ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_px) begin
						state_d = gfw_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = gfw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/gfw_datapath.sv
// Datapath: configuration registers, font store, address generation and pixel output.
module gfw_datapath #(
	parameter int unsigned GLYPH_ROWS = 8,
	parameter int unsigned GLYPH_COLS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration writes
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	// Request payload
	input  logic [1:0]          req_mode,
	input  logic [7:0]          req_cell_col,
	input  logic [7:0]          req_cell_row,
	input  logic [7:0]          req_char_code,
	input  logic [31:0]         req_colour,
	input  logic [2:0]          req_font_row,
	input  logic [7:0]          req_font_bits,
	// Pixel output
	input  logic                pix_ready,
	output logic                pix_valid,
	output logic [31:0]         pix_write_address,
	output logic [31:0]         pix_pixel_value,
	output logic                pix_last_pixel,
	// Controller link
	input  gfw_pkg::ctrl_cmd_t  cmd,
	output gfw_pkg::ctrl_sts_t  sts
);

	localparam int unsigned CNT_W  = gfw_pkg::CNT_W;
	localparam int unsigned LINE_W = 8 + CNT_W;        // cell_row * GLYPH_ROWS
	localparam int unsigned COFS_W = 8 + CNT_W + 2;    // 4 * cell_col * GLYPH_COLS
	localparam int unsigned PROD_W = 16 + LINE_W;      // line_pitch * line
	localparam int unsigned GW     = gfw_pkg::GLYPH_W;
	localparam logic [CNT_W-1:0] X_LAST = CNT_W'(GLYPH_COLS - 1);
	localparam logic [CNT_W-1:0] Y_LAST = CNT_W'(GLYPH_ROWS - 1);

	// Configuration registers
	logic [31:0] frame_base_q;
	logic [15:0] line_pitch_q;
	logic        rgb_order_q;

	// Draw context
	logic [GW-1:0]     glyph_q;
	logic [GW-1:0]     glyph_d;
	logic [31:0]       colour_q;
	logic [LINE_W-1:0] line0_q;
	logic [COFS_W-1:0] col_ofs_q;
	logic [PROD_W-1:0] prod_q;
	logic [31:0]       line_addr_q;
	logic [31:0]       addr_q;
	logic [CNT_W-1:0]  x_q;
	logic [CNT_W-1:0]  y_q;
	logic [CNT_W-1:0]  y_d;
	logic              x_last;
	logic              y_last;
	logic [31:0]       next_line;

	// Font store and its registered read
	logic [7:0]                     font_mem_q [gfw_pkg::FONT_DEPTH];
	logic [7:0]                     font_rd_q;
	logic [gfw_pkg::FONT_ADDR_W-1:0] wr_addr;
	logic [gfw_pkg::FONT_ADDR_W-1:0] rd_addr;

	// Output register
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [31:0] out_pixel_q;
	logic        out_last_q;

	// Configuration register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= gfw_pkg::FRAME_BASE_RST;
			line_pitch_q <= gfw_pkg::LINE_PITCH_RST;
			rgb_order_q  <= gfw_pkg::RGB_ORDER_RST;
		end else if (cfg_we) begin
			unique case (gfw_pkg::cfg_idx_t'(cfg_index))
				gfw_pkg::CFG_FRAME_BASE: frame_base_q <= cfg_data;
				gfw_pkg::CFG_LINE_PITCH: line_pitch_q <= cfg_data[15:0];
				gfw_pkg::CFG_RGB_ORDER:  rgb_order_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Pixel position flags and the address of the next glyph row.
	assign x_last    = (x_q == X_LAST);
	assign y_last    = (y_q == Y_LAST);
	assign next_line = line_addr_q + 32'(line_pitch_q);

	// Glyph and row that the counters hold after this edge; they address the
	// font store so that the read data always matches the current row.
	always_comb begin
		glyph_d = glyph_q;
		y_d     = y_q;
		if (cmd.start) begin
			glyph_d = (gfw_pkg::mode_t'(req_mode) == gfw_pkg::MODE_HEX)
				? gfw_pkg::hex_glyph(req_char_code) : req_char_code[GW-1:0];
			y_d     = '0;
		end else if (cmd.emit && x_last) begin
			y_d = y_q + CNT_W'(1);
		end
	end

	assign wr_addr = {req_char_code[GW-1:0], req_font_row};
	assign rd_addr = {glyph_d, y_d};

	// Font store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.font_wr) begin
			font_mem_q[wr_addr] <= req_font_bits;
		end
		font_rd_q <= font_mem_q[rd_addr];
	end

	// Draw context and pixel address generation.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			colour_q  <= gfw_pkg::order_colour(req_colour, rgb_order_q);
			line0_q   <= LINE_W'(req_cell_row) * LINE_W'(GLYPH_ROWS);
			col_ofs_q <= COFS_W'(req_cell_col) * COFS_W'(GLYPH_COLS * 4);
		end
		if (cmd.setup) begin
			prod_q <= PROD_W'(line_pitch_q) * PROD_W'(line0_q);
		end
		if (cmd.load_base) begin
			line_addr_q <= frame_base_q + 32'(prod_q) + 32'(col_ofs_q);
			addr_q      <= frame_base_q + 32'(prod_q) + 32'(col_ofs_q);
		end else if (cmd.emit) begin
			if (x_last) begin
				line_addr_q <= next_line;
				addr_q      <= next_line;
			end else begin
				addr_q <= addr_q + 32'd4;
			end
		end
	end

	// Pixel and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else begin
			glyph_q <= glyph_d;
			y_q     <= y_d;
			if (cmd.start || (cmd.emit && x_last)) begin
				x_q <= '0;
			end else if (cmd.emit) begin
				x_q <= x_q + CNT_W'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q  <= addr_q;
			out_pixel_q <= font_rd_q[x_q] ? colour_q : 32'h0000_0000;
			out_last_q  <= x_last && y_last;
		end
	end

	assign pix_valid         = out_valid_q;
	assign pix_write_address = out_addr_q;
	assign pix_pixel_value   = out_pixel_q;
	assign pix_last_pixel    = out_last_q;

	assign sts.out_free = !out_valid_q || pix_ready;
	assign sts.last_px  = x_last && y_last;

endmodule
